>>> rtl/assert_macros.svh
// Assertion macros shared by the tag frame walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tfw_pkg.sv
// Types and constants of the tag frame walker.
package tfw_pkg;

  localparam logic [31:0] HEADER_LEN = 32'd10;
  localparam logic [31:0] ID_LEN     = 32'd4;
  localparam logic [31:0] SIZE_LEN   = 32'd4;
  localparam logic [31:0] FLAGS_LEN  = 32'd2;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned GRP_CNT_W   = 3;

  localparam logic [7:0] CFG_MODE   = 8'd0;
  localparam logic [7:0] CFG_TARGET = 8'd1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ID,
    PH_SIZE,
    PH_FLAGS,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ID,
    KIND_PAYLOAD,
    KIND_MARK
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  // Results caused by one input byte, entry 0 goes out first.
  typedef struct packed {
    logic [GRP_CNT_W-1:0]        cnt;
    result_t [MAX_RESULTS-1:0]   res;
  } group_t;

endpackage

>>> rtl/tfw_parser.sv
// Frame parser: phase state machine and the results of each accepted byte.
`include "assert_macros.svh"

module tfw_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            file_start,
  input  logic            mode,
  input  logic [31:0]     target_frame_id,
  output tfw_pkg::group_t grp
);

  tfw_pkg::phase_t phase, phase_next;
  logic [31:0]     byte_counter, byte_counter_next;
  logic [31:0]     id_shift, id_shift_next;
  logic [31:0]     size_accum, size_accum_next;
  logic            frame_matched, frame_matched_next;

  // View of the state after an optional restart
  tfw_pkg::phase_t ph;
  logic [31:0]     cnt, ids, sz;
  logic            matched;
  logic [31:0]     cnt_inc, cnt_dec, id_new;
  logic            hit;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tfw_pkg::PH_HEADER;
      byte_counter  <= '0;
      id_shift      <= '0;
      size_accum    <= '0;
      frame_matched <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_counter  <= byte_counter_next;
      id_shift      <= id_shift_next;
      size_accum    <= size_accum_next;
      frame_matched <= frame_matched_next;
    end
  end

  // Next state and results
  always_comb begin
    ph      = file_start ? tfw_pkg::PH_HEADER : phase;
    cnt     = file_start ? '0 : byte_counter;
    ids     = file_start ? '0 : id_shift;
    sz      = file_start ? '0 : size_accum;
    matched = file_start ? 1'b0 : frame_matched;

    cnt_inc = cnt + 32'd1;
    cnt_dec = cnt - 32'd1;
    id_new  = {ids[23:0], data_byte};
    hit     = !mode || (id_new == target_frame_id);

    phase_next         = ph;
    byte_counter_next  = cnt;
    id_shift_next      = ids;
    size_accum_next    = sz;
    frame_matched_next = matched;

    grp.cnt = '0;
    for (int k = 0; k < tfw_pkg::MAX_RESULTS; k++) begin
      grp.res[k].data = data_byte;
      grp.res[k].kind = tfw_pkg::KIND_PAYLOAD;
      grp.res[k].last = 1'b0;
    end

    case (ph)
      tfw_pkg::PH_HEADER: begin
        byte_counter_next = cnt_inc;
        if (cnt_inc >= tfw_pkg::HEADER_LEN) begin
          phase_next        = tfw_pkg::PH_ID;
          byte_counter_next = '0;
          id_shift_next     = '0;
        end
      end
      tfw_pkg::PH_ID: begin
        if (cnt == '0 && data_byte == 8'd0) begin
          // zero byte where an ID should start ends the walk
          phase_next = tfw_pkg::PH_DONE;
        end else begin
          id_shift_next     = id_new;
          byte_counter_next = cnt_inc;
          if (cnt_inc >= tfw_pkg::ID_LEN) begin
            frame_matched_next = hit;
            if (hit) begin
              grp.cnt = tfw_pkg::GRP_CNT_W'(tfw_pkg::MAX_RESULTS);
              for (int k = 0; k < tfw_pkg::MAX_RESULTS; k++) begin
                grp.res[k].data = id_new[31-8*k -: 8];
                grp.res[k].kind = tfw_pkg::KIND_ID;
              end
            end
            phase_next        = tfw_pkg::PH_SIZE;
            byte_counter_next = '0;
            size_accum_next   = '0;
          end
        end
      end
      tfw_pkg::PH_SIZE: begin
        size_accum_next   = {sz[23:0], data_byte};
        byte_counter_next = cnt_inc;
        if (cnt_inc >= tfw_pkg::SIZE_LEN) begin
          phase_next        = tfw_pkg::PH_FLAGS;
          byte_counter_next = '0;
        end
      end
      tfw_pkg::PH_FLAGS: begin
        byte_counter_next = cnt_inc;
        if (cnt_inc >= tfw_pkg::FLAGS_LEN) begin
          if (sz == '0) begin
            // empty payload: end marker if the frame matched, then close the frame
            if (matched) begin
              grp.cnt         = tfw_pkg::GRP_CNT_W'(1);
              grp.res[0].data = 8'd0;
              grp.res[0].kind = tfw_pkg::KIND_MARK;
              grp.res[0].last = 1'b1;
            end
            phase_next         = (matched && mode) ? tfw_pkg::PH_DONE : tfw_pkg::PH_ID;
            byte_counter_next  = '0;
            id_shift_next      = '0;
            frame_matched_next = 1'b0;
          end else begin
            phase_next        = tfw_pkg::PH_PAYLOAD;
            byte_counter_next = sz;
          end
        end
      end
      tfw_pkg::PH_PAYLOAD: begin
        byte_counter_next = cnt_dec;
        if (matched) begin
          grp.cnt         = tfw_pkg::GRP_CNT_W'(1);
          grp.res[0].last = (cnt_dec == '0);
        end
        if (cnt_dec == '0) begin
          phase_next         = (matched && mode) ? tfw_pkg::PH_DONE : tfw_pkg::PH_ID;
          byte_counter_next  = '0;
          id_shift_next      = '0;
          frame_matched_next = 1'b0;
        end
      end
      default: begin
        // walk ended: ignore bytes until the next file starts
      end
    endcase
  end

  `ASSERT_NEXT(a_restart_header, clk, rst, accept && file_start, phase == tfw_pkg::PH_HEADER, "file start did not restart the header skip")
  `ASSERT_IMPL(a_payload_left, clk, rst, phase == tfw_pkg::PH_PAYLOAD, byte_counter != '0, "payload phase with no bytes left")
  `ASSERT_IMPL(a_done_silent, clk, rst, !file_start && phase == tfw_pkg::PH_DONE, grp.cnt == '0, "byte after the end of the walk produced results")

endmodule

>>> rtl/tag_frame_walker.sv
// Tag frame walker top level: configuration, parser, result group and output register.
// Each byte's results pass through the result group register, then the output register.
// Throughput: one byte per cycle while the result group is empty or its last result is
// being taken; the byte that completes an emitted frame ID loads four results, and the
// input stalls while they drain, one per cycle when the output register can take one.
// Reset clears the parser to header skip, mode and target ID to zero, all results dropped.
`include "assert_macros.svh"

module tag_frame_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic                               mode;
  logic [31:0]                        target_frame_id;
  logic                               in_xfer;
  logic                               grp_pop;
  tfw_pkg::group_t                    new_grp;
  tfw_pkg::group_t                    grp, grp_next;
  tfw_pkg::result_t                   out_res;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= 1'b0;
      target_frame_id <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tfw_pkg::CFG_MODE:   mode            <= cfg_data[0];
        tfw_pkg::CFG_TARGET: target_frame_id <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tfw_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .accept          (in_xfer),
    .data_byte       (data_byte),
    .file_start      (file_start),
    .mode            (mode),
    .target_frame_id (target_frame_id),
    .grp             (new_grp)
  );

  // Move one result into the output register when it is free or being taken
  assign grp_pop  = (grp.cnt != '0) && (!out_valid || out_ready);
  assign in_ready = (grp.cnt == '0) ||
                    ((grp.cnt == tfw_pkg::GRP_CNT_W'(1)) && grp_pop);
  assign in_xfer  = in_valid && in_ready;

  // Load a new group on transfer, else shift the drained entry out
  always_comb begin
    grp_next = grp;
    if (in_xfer) begin
      grp_next = new_grp;
    end else if (grp_pop) begin
      grp_next.cnt = grp.cnt - tfw_pkg::GRP_CNT_W'(1);
      for (int k = 0; k < tfw_pkg::MAX_RESULTS - 1; k++) begin
        grp_next.res[k] = grp.res[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp.res <= grp_next.res;
    if (rst) begin
      grp.cnt <= '0;
    end else begin
      grp.cnt <= grp_next.cnt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (grp_pop) begin
      out_res <= grp.res[0];
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (grp_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_byte   = out_res.data;
  assign out_kind   = out_res.kind;
  assign frame_last = out_res.last;

  `ASSERT_ALWAYS(a_grp_bound, clk, rst, grp.cnt <= tfw_pkg::GRP_CNT_W'(tfw_pkg::MAX_RESULTS), "result group overfilled")
  `ASSERT_IMPL(a_xfer_no_loss, clk, rst, in_xfer, (grp.cnt == '0) || grp_pop, "new group would overwrite pending results")
  `ASSERT_IMPL(a_pop_nonempty, clk, rst, grp_pop, grp.cnt != '0, "result taken from an empty group")

endmodule
